// ===== src/kifc_pkg.sv =====
// Package for the keyframe-indexed frame cache.
// Holds beat structs, operation and status codes, state and command types.
// Depends on nothing.
`timescale 1ns / 1ps
package kifc_pkg;

  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_CHANNELS    = 2;
  localparam logic [31:0] LIMIT_RESET = 32'd2097152;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_GET    = 3'd1;
  localparam logic [2:0] OP_BEFORE = 3'd2;
  localparam logic [2:0] OP_AFTER  = 3'd3;
  localparam logic [2:0] OP_NEWEST = 3'd4;
  localparam logic [2:0] OP_NEXT   = 3'd5;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_AWAIT      = 3'd1;
  localparam logic [2:0] ST_BADTYPE    = 3'd2;
  localparam logic [2:0] ST_NOTSTARTED = 3'd3;
  localparam logic [2:0] ST_RANGE      = 3'd4;
  localparam logic [2:0] ST_NOTFOUND   = 3'd5;

  localparam logic [1:0] KEY_KIND = 2'd1;
  localparam logic [1:0] BAD_KIND = 2'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic        channel;
    logic [23:0] frame_length;
    logic [1:0]  frame_kind;
    logic [63:0] time_stamp;
    logic [47:0] query_seq;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] found_seq;
    logic [23:0] found_length;
    logic [1:0]  found_kind;
    logic [63:0] found_stamp;
  } out_item_t;

  typedef struct packed {
    logic [23:0] len;
    logic [1:0]  kind;
    logic [63:0] stamp;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_EVICT, S_EV_DROP, S_INSERT,
    S_GET_RD, S_GET_CAP, S_SRCH_RD, S_SRCH_CHK, S_RESP
  } state_t;

  typedef enum logic [1:0] {DEC_DONE, DEC_ADD, DEC_GET, DEC_SRCH} dec_t;

  typedef struct packed {
    logic latch;
    logic decode;
    logic evict_rd;
    logic evict_drop;
    logic insert;
    logic get_rd;
    logic get_cap;
    logic srch_rd;
    logic srch_step;
    logic deliver;
  } ctrl_cmd_t;

  typedef struct packed {
    dec_t dec;
    logic ev_need;
    logic key_hit;
    logic srch_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== src/keyframe_indexed_frame_cache.sv =====
// Top level of the keyframe-indexed frame cache.
// Joins kifc_ctrl and kifc_datapath; uses kifc_pkg.
// The block handles one beat at a time. An add reads and drops each evicted record
// before its insert, a get reads one record, other immediate answers read none, and
// key searches read one record per step, since the record memory has one registered
// read port and the search walks the channel FIFO one record per read.
// Results wait in an output register, so a finished beat does not block input
// until the next result is ready. After reset no clearing pass is needed.
`timescale 1ns / 1ps
module keyframe_indexed_frame_cache import kifc_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int CHANNELS    = DEF_CHANNELS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  kifc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kifc_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .CHANNELS    (CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== src/kifc_ctrl.sv =====
// Controller state machine of the keyframe-indexed frame cache.
// Uses kifc_pkg; drives commands to kifc_datapath from its status.
`timescale 1ns / 1ps
module kifc_ctrl import kifc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        unique case (stat.dec)
          DEC_DONE: state_nxt = S_RESP;
          DEC_ADD:  state_nxt = S_EVICT;
          DEC_GET:  state_nxt = S_GET_RD;
          DEC_SRCH: state_nxt = S_SRCH_RD;
          default:  state_nxt = S_RESP;
        endcase
      end
      S_EVICT: begin
        if (stat.ev_need) begin
          cmd.evict_rd = 1'b1;
          state_nxt    = S_EV_DROP;
        end else begin
          state_nxt = S_INSERT;
        end
      end
      S_EV_DROP: begin
        cmd.evict_drop = 1'b1;
        state_nxt      = S_EVICT;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = S_RESP;
      end
      S_GET_RD: begin
        cmd.get_rd = 1'b1;
        state_nxt  = S_GET_CAP;
      end
      S_GET_CAP: begin
        cmd.get_cap = 1'b1;
        state_nxt   = S_RESP;
      end
      S_SRCH_RD: begin
        cmd.srch_rd = 1'b1;
        state_nxt   = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        cmd.srch_step = 1'b1;
        state_nxt = (stat.key_hit || stat.srch_last) ? S_RESP : S_SRCH_RD;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.deliver = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== src/kifc_datapath.sv =====
// Datapath of the keyframe-indexed frame cache: channel registers, record memory,
// search cursor and result registers. Uses kifc_pkg; commanded by kifc_ctrl.
`timescale 1ns / 1ps
module kifc_datapath import kifc_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int CHANNELS    = DEF_CHANNELS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_data,
  output out_item_t   out_data,
  output logic        out_valid,
  input  logic        out_ready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  ctrl_cmd_t   cmd,
  output dp_stat_t    stat
);

  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int TW  = 24 + CW;
  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  in_item_t        item_r;
  logic [31:0]     limit_r;
  logic            started_r [CHANNELS];
  logic [47:0]     seq_r     [CHANNELS];
  logic [TW-1:0]   tot_r     [CHANNELS];
  logic [CW-1:0]   cnt_r     [CHANNELS];
  logic [IW-1:0]   head_r    [CHANNELS];
  logic [CW-1:0]   cur_r;
  logic            bwd_r;
  out_item_t       pend_r;
  out_item_t       res_r;
  logic            out_valid_r;
  rec_t            rd_r;
  rec_t            mem_r [CHANNELS][TABLE_DEPTH];

  logic [CHW-1:0]  chi;
  logic            ch_ok;
  logic            st;
  logic [47:0]     seq;
  logic [TW-1:0]   tot;
  logic [CW-1:0]   cnt;
  logic [IW-1:0]   head;
  logic [47:0]     first;
  logic [47:0]     qdist;
  logic            d_in;
  logic [CW-1:0]   dpos;
  dec_t            dec;
  out_item_t       dec_res;
  logic [CW-1:0]   dec_cur;
  logic            dec_bwd;
  logic [IW-1:0]   cur_idx;
  logic [IW-1:0]   ins_idx;
  logic [IW-1:0]   rd_idx;

  function automatic logic [IW-1:0] wrap_idx(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(TABLE_DEPTH)) sum = sum - (CW+1)'(TABLE_DEPTH);
    return sum[IW-1:0];
  endfunction

  assign chi   = CHW'(item_r.channel);
  assign ch_ok = (int'(item_r.channel) < CHANNELS);
  assign st    = started_r[chi];
  assign seq   = seq_r[chi];
  assign tot   = tot_r[chi];
  assign cnt   = cnt_r[chi];
  assign head  = head_r[chi];
  assign first = seq - 48'(cnt);
  assign qdist = item_r.query_seq - first;
  assign d_in  = qdist < 48'(cnt);
  assign dpos  = qdist[CW-1:0];

  assign cur_idx = wrap_idx(head, cur_r);
  assign ins_idx = wrap_idx(head, cnt);
  assign rd_idx  = cmd.evict_rd ? head : cur_idx;

  always_comb begin
    dec     = DEC_DONE;
    dec_res = '0;
    dec_cur = '0;
    dec_bwd = 1'b0;
    priority if (item_r.operation > OP_NEXT) begin
      dec_res.status = ST_RANGE;
    end else if (!ch_ok) begin
      dec_res.status = ST_NOTSTARTED;
    end else if (item_r.operation == OP_ADD) begin
      if (item_r.frame_kind == BAD_KIND) dec_res.status = ST_BADTYPE;
      else if (!st && item_r.frame_kind != KEY_KIND) dec_res.status = ST_AWAIT;
      else dec = DEC_ADD;
    end else if (!st) begin
      dec_res.status = ST_NOTSTARTED;
    end else if (item_r.operation == OP_NEXT) begin
      dec_res.found_seq = seq;
    end else if (item_r.operation == OP_NEWEST) begin
      if (cnt == '0) begin
        dec_res.status = ST_NOTFOUND;
      end else begin
        dec     = DEC_SRCH;
        dec_cur = cnt - CW'(1);
        dec_bwd = 1'b1;
      end
    end else if (item_r.query_seq >= seq) begin
      dec_res.status = ST_RANGE;
    end else if (!d_in) begin
      dec_res.status = ST_NOTFOUND;
    end else if (item_r.operation == OP_GET) begin
      dec     = DEC_GET;
      dec_cur = dpos;
    end else if (item_r.operation == OP_BEFORE) begin
      if (dpos == '0) begin
        dec_res.status = ST_NOTFOUND;
      end else begin
        dec     = DEC_SRCH;
        dec_cur = dpos - CW'(1);
        dec_bwd = 1'b1;
      end
    end else begin
      if ((CW+1)'(dpos) + (CW+1)'(1) >= (CW+1)'(cnt)) begin
        dec_res.status = ST_NOTFOUND;
      end else begin
        dec     = DEC_SRCH;
        dec_cur = dpos + CW'(1);
      end
    end
  end

  assign stat.dec       = dec;
  assign stat.ev_need   = (cnt != '0) &&
                          (64'(tot) >= 64'(limit_r) || 32'(cnt) >= 32'(TABLE_DEPTH));
  assign stat.key_hit   = (rd_r.kind == KEY_KIND);
  assign stat.srch_last = bwd_r ? (cur_r == '0)
                                : ((CW+1)'(cur_r) + (CW+1)'(1) == (CW+1)'(cnt));
  assign stat.out_free  = !out_valid_r || out_ready;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (cmd.evict_rd || cmd.get_rd || cmd.srch_rd) rd_r <= mem_r[chi][rd_idx];
    if (cmd.insert) begin
      mem_r[chi][ins_idx] <= '{len: item_r.frame_length, kind: item_r.frame_kind,
                               stamp: item_r.time_stamp};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) item_r <= in_data;
    if (cmd.decode) begin
      pend_r <= dec_res;
      cur_r  <= dec_cur;
      bwd_r  <= dec_bwd;
    end
    if (cmd.get_cap) begin
      pend_r.found_seq    <= item_r.query_seq;
      pend_r.found_length <= rd_r.len;
      pend_r.found_kind   <= rd_r.kind;
      pend_r.found_stamp  <= rd_r.stamp;
    end
    if (cmd.srch_step) begin
      if (stat.key_hit) pend_r.found_seq <= first + 48'(cur_r);
      else if (stat.srch_last) pend_r.status <= ST_NOTFOUND;
      else cur_r <= bwd_r ? cur_r - CW'(1) : cur_r + CW'(1);
    end
    if (cmd.deliver) res_r <= pend_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        started_r[c] <= 1'b0;
        seq_r[c]     <= '0;
        tot_r[c]     <= '0;
        cnt_r[c]     <= '0;
        head_r[c]    <= '0;
      end
    end else begin
      if (cfg_valid) limit_r <= cfg_data;
      if (cmd.deliver) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cmd.decode && dec == DEC_ADD) started_r[chi] <= 1'b1;
      if (cmd.evict_drop) begin
        tot_r[chi]  <= tot - TW'(rd_r.len);
        head_r[chi] <= wrap_idx(head, CW'(1));
        cnt_r[chi]  <= cnt - CW'(1);
      end
      if (cmd.insert) begin
        tot_r[chi] <= tot + TW'(item_r.frame_length);
        cnt_r[chi] <= cnt + CW'(1);
        seq_r[chi] <= seq + 48'd1;
      end
    end
  end

endmodule

// ===== dv/keyframe_indexed_frame_cache_tb.sv =====
// Testbench for keyframe_indexed_frame_cache: directed table, then random traffic.
// Predicts every result with a behavioral copy of the frame cache; uses kifc_pkg.
`timescale 1ns / 1ps
module keyframe_indexed_frame_cache_tb;
  import kifc_pkg::*;

  localparam int DEPTH = 256;
  localparam int MAX_CYCLES = 2000000;

  typedef struct {
    logic [47:0] seq;
    logic [63:0] stamp;
    logic [23:0] len;
    logic [1:0]  kind;
  } frame_t;

  typedef struct {
    in_item_t  item;
    logic      known;
    out_item_t want;
  } vector_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  logic [31:0] limit_q;
  logic        started_q [2];
  logic [47:0] seq_next_q [2];
  logic [32:0] total_q [2];
  frame_t      fifo_q [2][$];
  out_item_t   pending_q [$];
  vector_t     vectors [$];
  int          errors;
  int          cycles;
  int          beats_out;
  int          adds_seen;
  bit          stall_busy;

  keyframe_indexed_frame_cache u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic out_item_t cache_answer(in_item_t it);
    out_item_t r;
    int ch;
    int pos;
    r = '0;
    ch = it.channel;
    if (it.operation > OP_NEXT) begin
      r.status = ST_RANGE;
      return r;
    end
    if (it.operation == OP_ADD) begin
      if (it.frame_kind == BAD_KIND) begin
        r.status = ST_BADTYPE;
        return r;
      end
      if (!started_q[ch]) begin
        if (it.frame_kind != KEY_KIND) begin
          r.status = ST_AWAIT;
          return r;
        end
        started_q[ch] = 1'b1;
      end
      while (fifo_q[ch].size() > 0 &&
             (total_q[ch] >= {1'b0, limit_q} || fifo_q[ch].size() >= DEPTH)) begin
        total_q[ch] -= fifo_q[ch][0].len;
        void'(fifo_q[ch].pop_front());
      end
      fifo_q[ch].push_back('{seq_next_q[ch], it.time_stamp, it.frame_length, it.frame_kind});
      total_q[ch] += it.frame_length;
      seq_next_q[ch] += 1;
      adds_seen++;
      return r;
    end
    if (!started_q[ch]) begin
      r.status = ST_NOTSTARTED;
      return r;
    end
    if (it.operation == OP_NEXT) begin
      r.found_seq = seq_next_q[ch];
      return r;
    end
    if (it.operation == OP_NEWEST) begin
      for (int i = fifo_q[ch].size() - 1; i >= 0; i--)
        if (fifo_q[ch][i].kind == KEY_KIND) begin
          r.found_seq = fifo_q[ch][i].seq;
          return r;
        end
      r.status = ST_NOTFOUND;
      return r;
    end
    if (it.query_seq >= seq_next_q[ch]) begin
      r.status = ST_RANGE;
      return r;
    end
    pos = -1;
    for (int i = 0; i < fifo_q[ch].size(); i++)
      if (fifo_q[ch][i].seq == it.query_seq) pos = i;
    if (pos < 0) begin
      r.status = ST_NOTFOUND;
      return r;
    end
    if (it.operation == OP_GET) begin
      r.found_seq = fifo_q[ch][pos].seq;
      r.found_length = fifo_q[ch][pos].len;
      r.found_kind = fifo_q[ch][pos].kind;
      r.found_stamp = fifo_q[ch][pos].stamp;
      return r;
    end
    if (it.operation == OP_BEFORE) begin
      for (int i = pos - 1; i >= 0; i--)
        if (fifo_q[ch][i].kind == KEY_KIND) begin
          r.found_seq = fifo_q[ch][i].seq;
          return r;
        end
    end else begin
      for (int i = pos + 1; i < fifo_q[ch].size(); i++)
        if (fifo_q[ch][i].kind == KEY_KIND) begin
          r.found_seq = fifo_q[ch][i].seq;
          return r;
        end
    end
    r.status = ST_NOTFOUND;
    return r;
  endfunction

  function automatic in_item_t make_item(logic [2:0] op, logic ch, logic [23:0] len,
                                         logic [1:0] kind, logic [63:0] ts,
                                         logic [47:0] q);
    in_item_t it;
    it.operation = op;
    it.channel = ch;
    it.frame_length = len;
    it.frame_kind = kind;
    it.time_stamp = ts;
    it.query_seq = q;
    return it;
  endfunction

  function automatic out_item_t make_result(logic [2:0] st, logic [47:0] s);
    out_item_t r;
    r = '0;
    r.status = st;
    r.found_seq = s;
    return r;
  endfunction

  task automatic send_beat(in_item_t it, logic known, out_item_t want);
    out_item_t p;
    p = cache_answer(it);
    if (known && p !== want) begin
      $display("%0t directed row disagrees: expected %h actual predictor %h", $time, want, p);
      errors++;
    end
    pending_q.push_back(p);
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 8)) @(negedge clk);
  endtask

  task automatic write_limit(logic [31:0] v);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (DEPTH * 2 + 20) @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    limit_q = v;
  endtask

  task automatic random_run(int count, bit noisy);
    in_item_t it;
    int burst;
    int ch;
    int hi;
    logic [2:0] op;
    logic [23:0] len;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      ch = $urandom_range(0, 1);
      hi = int'(seq_next_q[ch]);
      if ($urandom_range(0, 99) < 45) op = OP_ADD;
      else op = 3'($urandom_range(1, noisy ? 7 : 5));
      len = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4000));
      it = make_item(op, 1'(ch), len,
                     ($urandom_range(0, 9) < 4) ? KEY_KIND : 2'($urandom_range(0, 3)),
                     {$urandom, $urandom},
                     ($urandom_range(0, 9) == 0) ? 48'({$urandom, $urandom}) :
                       48'($urandom_range(hi > 300 ? hi - 300 : 0, hi + 1)));
      send_beat(it, 1'b0, '0);
      if (burst == 0) begin
        idle_gap();
        burst = $urandom_range(1, 20);
      end else begin
        burst--;
      end
    end
    in_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    out_item_t w;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      beats_out <= beats_out + 1;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result beat: actual %h", $time, out_data);
        errors++;
      end else begin
        w = pending_q.pop_front();
        if (out_data.status !== w.status || out_data.found_seq !== w.found_seq ||
            out_data.found_length !== w.found_length ||
            out_data.found_kind !== w.found_kind ||
            out_data.found_stamp !== w.found_stamp) begin
          $display("%0t result mismatch: expected %h actual %h", $time, w, out_data);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_busy) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0) || (cycles % 400 < 100);
  end

  always @(posedge clk) begin
    if (cycles >= MAX_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    vector_t v;
    errors = 0;
    cycles = 0;
    beats_out = 0;
    adds_seen = 0;
    stall_busy = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    cfg_valid = 0;
    cfg_data = '0;
    limit_q = LIMIT_RESET;
    for (int c = 0; c < 2; c++) begin
      started_q[c] = 0;
      seq_next_q[c] = '0;
      total_q[c] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    vectors = '{
      '{make_item(OP_NEXT, 0, 0, 0, 0, 0), 1, make_result(ST_NOTSTARTED, 0)},
      '{make_item(OP_GET, 1, 0, 0, 0, 0), 1, make_result(ST_NOTSTARTED, 0)},
      '{make_item(OP_ADD, 0, 24'hFFFFFF, 2, '1, 0), 1, make_result(ST_AWAIT, 0)},
      '{make_item(OP_ADD, 0, 5, BAD_KIND, 0, 0), 1, make_result(ST_BADTYPE, 0)},
      '{make_item(3'd6, 0, 0, 0, 0, 0), 1, make_result(ST_RANGE, 0)},
      '{make_item(3'd7, 1, '1, 3, '1, '1), 1, make_result(ST_RANGE, 0)},
      '{make_item(OP_NEWEST, 0, 0, 0, 0, 0), 1, make_result(ST_NOTSTARTED, 0)},
      '{make_item(OP_ADD, 0, 24'hFFFFFF, KEY_KIND, '1, 0), 1, make_result(ST_OK, 0)},
      '{make_item(OP_ADD, 0, 0, 0, 0, 0), 1, make_result(ST_OK, 0)},
      '{make_item(OP_ADD, 0, 100, 2, 64'h8000_0000_0000_0001, 0), 1, make_result(ST_OK, 0)},
      '{make_item(OP_ADD, 0, 7, KEY_KIND, 64'h1234, 0), 1, make_result(ST_OK, 0)},
      '{make_item(OP_GET, 0, 0, 0, 0, 0), 0, '0},
      '{make_item(OP_GET, 0, 0, 0, 0, 2), 0, '0},
      '{make_item(OP_GET, 0, 0, 0, 0, 4), 1, make_result(ST_RANGE, 0)},
      '{make_item(OP_GET, 0, 0, 0, 0, '1), 1, make_result(ST_RANGE, 0)},
      '{make_item(OP_BEFORE, 0, 0, 0, 0, 3), 1, make_result(ST_NOTFOUND, 0)},
      '{make_item(OP_BEFORE, 0, 0, 0, 0, 0), 1, make_result(ST_NOTFOUND, 0)},
      '{make_item(OP_AFTER, 0, 0, 0, 0, 1), 1, make_result(ST_OK, 3)},
      '{make_item(OP_AFTER, 0, 0, 0, 0, 3), 1, make_result(ST_NOTFOUND, 0)},
      '{make_item(OP_NEWEST, 0, 0, 0, 0, 0), 1, make_result(ST_OK, 3)},
      '{make_item(OP_NEXT, 0, 0, 0, 0, 0), 1, make_result(ST_OK, 4)},
      '{make_item(OP_ADD, 1, 1, KEY_KIND, 0, 0), 1, make_result(ST_OK, 0)},
      '{make_item(OP_NEXT, 1, 0, 0, 0, 0), 1, make_result(ST_OK, 1)}
    };
    stall_busy = 1;
    foreach (vectors[i]) begin
      v = vectors[i];
      send_beat(v.item, v.known, v.want);
    end
    stall_busy = 0;

    random_run(150, 1);
    write_limit(32'd1);
    random_run(100, 1);
    write_limit(32'hFFFFFFFF);
    random_run(200, 0);
    write_limit(32'd20000);
    random_run(150, 1);

    while (pending_q.size() != 0 && cycles < MAX_CYCLES) @(negedge clk);
    repeat (DEPTH * 2 + 20) @(negedge clk);
    $display("Covered %0d result beats, %0d stored frames, limits 1, max, 20000, reset.",
             beats_out, adds_seen);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
src/kifc_pkg.sv
src/kifc_ctrl.sv
src/kifc_datapath.sv
src/keyframe_indexed_frame_cache.sv
dv/keyframe_indexed_frame_cache_tb.sv
